// ----- rtl/lid_pkg.sv -----
// Shared types, widths and a helper function for the line intersection and distance block.
package lid_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_BITS = 16;

  // Replacement direction x for a zero direction: one unit in Q16.16.
  localparam logic signed [COORD_W-1:0] DIR_ONE = COORD_W'(64'd1 << FRAC_BITS);

  localparam int unsigned PROD_W  = 2 * COORD_W;      // coordinate by coordinate
  localparam int unsigned DET_W   = 2 * COORD_W + 1;  // c1, c2 and det
  localparam int unsigned DIFF_W  = COORD_W + 1;      // query point minus base point
  localparam int unsigned NUM_W   = 2 * COORD_W + 2;  // distance numerator
  localparam int unsigned HL_W    = DET_W + 1;        // partial sums of the Cramer numerators
  localparam int unsigned NX_W    = 98;               // Cramer numerator, signed
  localparam int unsigned NXMAG_W = NX_W - 1;
  localparam int unsigned DMAG_W  = 64;               // divisor magnitude
  localparam int unsigned N2_W    = 128;              // squared distance numerator

  localparam int unsigned XDIV_STEPS = 32;            // quotient bits of the crossing divide
  localparam int unsigned GDIV_STEPS = 64;            // quotient bits of the distance divide
  localparam int unsigned ROOT_W     = 32;            // bits of the square root
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned RAD_W      = 2 * ROOT_W;

  localparam logic [COORD_W-1:0] POS_LIM = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_LIM = {1'b1, {(COORD_W-1){1'b0}}};

  // Operands of one item as taken from the slave side.
  typedef struct packed {
    logic                      mode;
    logic signed [COORD_W-1:0] a_point_x;
    logic signed [COORD_W-1:0] a_point_y;
    logic signed [COORD_W-1:0] a_dir_x;
    logic signed [COORD_W-1:0] a_dir_y;
    logic signed [COORD_W-1:0] b_point_x;
    logic signed [COORD_W-1:0] b_point_y;
    logic signed [COORD_W-1:0] b_dir_x;
    logic signed [COORD_W-1:0] b_dir_y;
  } op_t;

  // Working set of the divider pipeline: partial remainder and a shift register that
  // feeds dividend bits in at the top and collects quotient bits at the bottom.
  typedef struct packed {
    logic                    mode;
    logic                    par;
    logic                    neg_x;
    logic                    neg_y;
    logic                    ovf_x;
    logic                    ovf_y;
    logic                    ovf_g;
    logic [DMAG_W-1:0]       det_mag;
    logic [DMAG_W-1:0]       rx;
    logic [XDIV_STEPS-1:0]   lx;
    logic [DMAG_W-1:0]       ry;
    logic [XDIV_STEPS-1:0]   ly;
    logic [DMAG_W-1:0]       s;
    logic [DMAG_W-1:0]       rg;
    logic [GDIV_STEPS-1:0]   lg;
  } div_t;

  // Working set of the square root pipeline.
  typedef struct packed {
    logic                    mode;
    logic                    par;
    logic                    neg_x;
    logic                    neg_y;
    logic                    ovf_x;
    logic                    ovf_y;
    logic                    ovf_g;
    logic [XDIV_STEPS-1:0]   qx;
    logic [XDIV_STEPS-1:0]   qy;
    logic [RAD_W-1:0]        rad;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
  } sqr_t;

  typedef struct packed {
    logic [DMAG_W-1:0] r;
    logic              q;
  } dstep_t;

  // One restoring division step: a remainder that starts below the divisor stays below it.
  function automatic dstep_t div_step(input logic [DMAG_W-1:0] r, input logic b,
                                      input logic [DMAG_W-1:0] d);
    logic [DMAG_W:0] t;
    logic [DMAG_W:0] diff;
    dstep_t          o;
    t    = {r, b};
    diff = t - {1'b0, d};
    o.q  = (t >= {1'b0, d});
    o.r  = o.q ? diff[DMAG_W-1:0] : t[DMAG_W-1:0];
    return o;
  endfunction

endpackage

// ----- rtl/line_intersect_and_distance_2d.sv -----
// Top level of the 2-D line intersection and point to line distance pipeline.
// Throughput: one transfer per cycle unless a waiting result is not taken; the 64-step
// distance divider (one quotient bit a stage) and the 32-step square root (one root bit a
// stage) set the depth.
// Reset: rst_ni is asynchronous and active low; it clears every valid bit, so the
// pipeline comes out of reset empty and ready.
module line_intersect_and_distance_2d (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_point_x, a_point_y, a_dir_x, a_dir_y, b_point_x, b_point_y, b_dir_x, b_dir_y
  input  logic [255:0] s_axis_tdata,
  // mode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cross_x, cross_y, gap
  output logic [95:0]  m_axis_tdata,
  // is_par, overflow
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned CW = lid_pkg::COORD_W;

  // The whole pipeline moves as one; it halts only when a finished result is waiting
  // in the output register and the master side is not taking it.
  logic          adv;
  logic          out_valid_q;
  logic [95:0]   out_data_q;
  logic [1:0]    out_user_q;
  logic [95:0]   out_data_d;
  logic [1:0]    out_user_d;

  lid_pkg::op_t  op;
  logic          fr_valid;
  lid_pkg::div_t fr_div;
  logic          dv_valid;
  lid_pkg::div_t dv_div;
  logic          sq_valid;
  lid_pkg::sqr_t sq_res;

  logic [CW:0]   fin_x;
  logic [CW:0]   fin_y;
  logic [CW-1:0] gap;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  assign op.mode      = s_axis_tuser[0];
  assign op.a_point_x = $signed(s_axis_tdata[31:0]);
  assign op.a_point_y = $signed(s_axis_tdata[63:32]);
  assign op.a_dir_x   = $signed(s_axis_tdata[95:64]);
  assign op.a_dir_y   = $signed(s_axis_tdata[127:96]);
  assign op.b_point_x = $signed(s_axis_tdata[159:128]);
  assign op.b_point_y = $signed(s_axis_tdata[191:160]);
  assign op.b_dir_x   = $signed(s_axis_tdata[223:192]);
  assign op.b_dir_y   = $signed(s_axis_tdata[255:224]);

  lid_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid),
    .op_i    (op),
    .valid_o (fr_valid),
    .div_o   (fr_div)
  );

  lid_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_valid),
    .div_i   (fr_div),
    .valid_o (dv_valid),
    .div_o   (dv_div)
  );

  lid_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (dv_valid),
    .div_i   (dv_div),
    .valid_o (sq_valid),
    .sqr_o   (sq_res)
  );

  // Sign and saturate a crossing quotient. A quotient that was caught as too large at
  // the front is treated as non-zero, so it saturates on the side its sign gives.
  // The top bit of the result says that the value saturated.
  function automatic logic [CW:0] fin_coord(input logic [CW-1:0] q, input logic big,
                                            input logic sgn);
    logic          neg;
    logic [CW-1:0] lim;
    logic          sat;
    logic [CW-1:0] mag;
    logic [CW-1:0] val;
    neg = sgn && (big || (q != '0));
    lim = neg ? lid_pkg::NEG_LIM : lid_pkg::POS_LIM;
    sat = big || (q > lim);
    mag = sat ? lim : q;
    val = neg ? (~mag + CW'(1)) : mag;
    return {sat, val};
  endfunction

  assign fin_x = fin_coord(sq_res.qx, sq_res.ovf_x, sq_res.neg_x);
  assign fin_y = fin_coord(sq_res.qy, sq_res.ovf_y, sq_res.neg_y);
  assign gap   = sq_res.ovf_g ? '1 : sq_res.root;

  always_comb begin
    if (sq_res.mode) begin
      // Distance: the crossing lanes carried nothing of use.
      out_data_d = {gap, {(2*CW){1'b0}}};
      out_user_d = {sq_res.ovf_g, 1'b0};
    end else if (sq_res.par) begin
      // Parallel or coincident lines give no crossing point.
      out_data_d = '0;
      out_user_d = 2'b01;
    end else begin
      out_data_d = {{CW{1'b0}}, fin_y[CW-1:0], fin_x[CW-1:0]};
      out_user_d = {fin_x[CW] | fin_y[CW], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- rtl/lid_front.sv -----
// Front pipeline: direction fix, products, implicit line forms and divider set-up.
module lid_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  lid_pkg::op_t  op_i,
  output logic          valid_o,
  output lid_pkg::div_t div_o
);

  localparam int unsigned CW = lid_pkg::COORD_W;
  localparam int unsigned PW = lid_pkg::PROD_W;
  localparam int unsigned DW = lid_pkg::DET_W;
  localparam int unsigned EW = lid_pkg::DIFF_W;
  localparam int unsigned NW = lid_pkg::NUM_W;
  localparam int unsigned HW = lid_pkg::HL_W;
  localparam int unsigned XW = lid_pkg::NX_W;
  localparam int unsigned MW = lid_pkg::NXMAG_W;
  localparam int unsigned QW = lid_pkg::XDIV_STEPS;
  localparam int unsigned GW = lid_pkg::DMAG_W;
  localparam int unsigned N2 = lid_pkg::N2_W;
  localparam int unsigned NSTG = 8;

  logic [NSTG-1:0] vld_q;

  // Stage 0
  logic                 s0_mode_q;
  logic signed [CW-1:0] s0_pxa_q, s0_pya_q, s0_dxa_q, s0_dya_q;
  logic signed [CW-1:0] s0_pxb_q, s0_pyb_q, s0_dxb_q, s0_dyb_q;
  logic signed [EW-1:0] s0_ex_q, s0_ey_q;
  logic signed [CW-1:0] dxa_d, dya_d, dxb_d, dyb_d;
  // Stage 1
  logic                 s1_mode_q;
  logic signed [CW-1:0] s1_dxa_q, s1_dya_q, s1_dxb_q, s1_dyb_q;
  logic signed [PW-1:0] s1_ya_xa_q, s1_xa_ya_q, s1_yb_xb_q, s1_xb_yb_q;
  logic signed [PW-1:0] s1_xa_yb_q, s1_ya_xb_q, s1_sqx_q, s1_sqy_q;
  logic signed [DW-1:0] s1_ya_ex_q, s1_xa_ey_q;
  // Stage 2
  logic                 s2_mode_q;
  logic signed [CW-1:0] s2_dxa_q, s2_dya_q, s2_dxb_q, s2_dyb_q;
  logic signed [DW-1:0] s2_c1_q, s2_c2_q, s2_det_q;
  logic signed [NW-1:0] s2_n_q;
  logic [GW-1:0]        s2_s_q;
  // Stage 3
  logic                 s3_mode_q;
  logic signed [DW-1:0] s3_det_q;
  logic signed [DW-1:0] s3_pa_q, s3_pb_q, s3_pc_q, s3_pd_q;
  logic signed [DW-1:0] s3_pe_q, s3_pf_q, s3_pg_q, s3_ph_q;
  logic [GW-1:0]        s3_nabs_q, s3_s_q;
  logic signed [NW-1:0] n_neg;
  // Stage 4
  logic                 s4_mode_q;
  logic signed [DW-1:0] s4_det_q;
  logic signed [HW-1:0] s4_hix_q, s4_lox_q, s4_hiy_q, s4_loy_q;
  logic [GW-1:0]        s4_hh_q, s4_ll_q, s4_hl_q, s4_s_q;
  // Stage 5
  logic                 s5_mode_q;
  logic signed [DW-1:0] s5_det_q;
  logic signed [XW-1:0] s5_nx_q, s5_ny_q;
  logic [N2-1:0]        s5_n2_q;
  logic [GW-1:0]        s5_s_q;
  // Stage 6
  logic                 s6_mode_q, s6_par_q, s6_negx_q, s6_negy_q;
  logic [MW-1:0]        s6_nxm_q, s6_nym_q;
  logic [GW-1:0]        s6_detm_q;
  logic [N2-1:0]        s6_n2_q;
  logic [GW-1:0]        s6_s_q;
  logic signed [XW-1:0] nx_neg, ny_neg;
  logic signed [DW-1:0] det_neg;
  // Stage 7
  lid_pkg::div_t        s7_q;

  always_comb begin
    dxa_d = op_i.a_dir_x;
    dya_d = op_i.a_dir_y;
    dxb_d = op_i.b_dir_x;
    dyb_d = op_i.b_dir_y;
    if (op_i.a_dir_x == '0 && op_i.a_dir_y == '0) begin
      dxa_d = lid_pkg::DIR_ONE;
    end
    if (op_i.b_dir_x == '0 && op_i.b_dir_y == '0) begin
      dxb_d = lid_pkg::DIR_ONE;
    end
  end

  assign n_neg   = -s2_n_q;
  assign nx_neg  = -s5_nx_q;
  assign ny_neg  = -s5_ny_q;
  assign det_neg = -s5_det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // Stage 0: register operands, fix zero directions, form the point offset.
      s0_mode_q <= op_i.mode;
      s0_pxa_q  <= op_i.a_point_x;
      s0_pya_q  <= op_i.a_point_y;
      s0_pxb_q  <= op_i.b_point_x;
      s0_pyb_q  <= op_i.b_point_y;
      s0_dxa_q  <= dxa_d;
      s0_dya_q  <= dya_d;
      s0_dxb_q  <= dxb_d;
      s0_dyb_q  <= dyb_d;
      s0_ex_q   <= EW'(op_i.b_point_x) - EW'(op_i.a_point_x);
      s0_ey_q   <= EW'(op_i.b_point_y) - EW'(op_i.a_point_y);

      // Stage 1: all first-order products.
      s1_mode_q  <= s0_mode_q;
      s1_dxa_q   <= s0_dxa_q;
      s1_dya_q   <= s0_dya_q;
      s1_dxb_q   <= s0_dxb_q;
      s1_dyb_q   <= s0_dyb_q;
      s1_ya_xa_q <= PW'(s0_dya_q) * PW'(s0_pxa_q);
      s1_xa_ya_q <= PW'(s0_dxa_q) * PW'(s0_pya_q);
      s1_yb_xb_q <= PW'(s0_dyb_q) * PW'(s0_pxb_q);
      s1_xb_yb_q <= PW'(s0_dxb_q) * PW'(s0_pyb_q);
      s1_xa_yb_q <= PW'(s0_dxa_q) * PW'(s0_dyb_q);
      s1_ya_xb_q <= PW'(s0_dya_q) * PW'(s0_dxb_q);
      s1_sqx_q   <= PW'(s0_dxa_q) * PW'(s0_dxa_q);
      s1_sqy_q   <= PW'(s0_dya_q) * PW'(s0_dya_q);
      s1_ya_ex_q <= DW'(s0_dya_q) * DW'(s0_ex_q);
      s1_xa_ey_q <= DW'(s0_dxa_q) * DW'(s0_ey_q);

      // Stage 2: implicit constants, determinant, distance numerator and norm.
      s2_mode_q <= s1_mode_q;
      s2_dxa_q  <= s1_dxa_q;
      s2_dya_q  <= s1_dya_q;
      s2_dxb_q  <= s1_dxb_q;
      s2_dyb_q  <= s1_dyb_q;
      s2_c1_q   <= DW'(s1_ya_xa_q) - DW'(s1_xa_ya_q);
      s2_c2_q   <= DW'(s1_yb_xb_q) - DW'(s1_xb_yb_q);
      s2_det_q  <= DW'(s1_xa_yb_q) - DW'(s1_ya_xb_q);
      s2_n_q    <= NW'(s1_ya_ex_q) - NW'(s1_xa_ey_q);
      s2_s_q    <= $unsigned(s1_sqx_q) + $unsigned(s1_sqy_q);

      // Stage 3: direction times c, split into low and high halves of c.
      s3_mode_q <= s2_mode_q;
      s3_det_q  <= s2_det_q;
      s3_s_q    <= s2_s_q;
      s3_nabs_q <= s2_n_q[NW-1] ? n_neg[GW-1:0] : s2_n_q[GW-1:0];
      s3_pa_q   <= DW'(s2_dxa_q) * DW'($signed({1'b0, s2_c2_q[CW-1:0]}));
      s3_pb_q   <= DW'(s2_dxa_q) * DW'($signed(s2_c2_q[DW-1:CW]));
      s3_pc_q   <= DW'(s2_dxb_q) * DW'($signed({1'b0, s2_c1_q[CW-1:0]}));
      s3_pd_q   <= DW'(s2_dxb_q) * DW'($signed(s2_c1_q[DW-1:CW]));
      s3_pe_q   <= DW'(s2_dya_q) * DW'($signed({1'b0, s2_c2_q[CW-1:0]}));
      s3_pf_q   <= DW'(s2_dya_q) * DW'($signed(s2_c2_q[DW-1:CW]));
      s3_pg_q   <= DW'(s2_dyb_q) * DW'($signed({1'b0, s2_c1_q[CW-1:0]}));
      s3_ph_q   <= DW'(s2_dyb_q) * DW'($signed(s2_c1_q[DW-1:CW]));

      // Stage 4: half sums of the numerators; halves of the squared numerator.
      s4_mode_q <= s3_mode_q;
      s4_det_q  <= s3_det_q;
      s4_s_q    <= s3_s_q;
      s4_hix_q  <= HW'(s3_pb_q) - HW'(s3_pd_q);
      s4_lox_q  <= HW'(s3_pa_q) - HW'(s3_pc_q);
      s4_hiy_q  <= HW'(s3_pf_q) - HW'(s3_ph_q);
      s4_loy_q  <= HW'(s3_pe_q) - HW'(s3_pg_q);
      s4_hh_q   <= GW'(s3_nabs_q[GW-1:CW]) * GW'(s3_nabs_q[GW-1:CW]);
      s4_ll_q   <= GW'(s3_nabs_q[CW-1:0]) * GW'(s3_nabs_q[CW-1:0]);
      s4_hl_q   <= GW'(s3_nabs_q[GW-1:CW]) * GW'(s3_nabs_q[CW-1:0]);

      // Stage 5: full numerators.
      s5_mode_q <= s4_mode_q;
      s5_det_q  <= s4_det_q;
      s5_s_q    <= s4_s_q;
      s5_nx_q   <= (XW'(s4_hix_q) <<< CW) + XW'(s4_lox_q);
      s5_ny_q   <= (XW'(s4_hiy_q) <<< CW) + XW'(s4_loy_q);
      s5_n2_q   <= {s4_hh_q, s4_ll_q} + {{(N2-GW-CW-1){1'b0}}, s4_hl_q, {(CW+1){1'b0}}};

      // Stage 6: magnitudes and quotient signs.
      s6_mode_q <= s5_mode_q;
      s6_par_q  <= (s5_det_q == '0);
      s6_negx_q <= s5_nx_q[XW-1] ^ s5_det_q[DW-1];
      s6_negy_q <= s5_ny_q[XW-1] ^ s5_det_q[DW-1];
      s6_nxm_q  <= s5_nx_q[XW-1] ? nx_neg[MW-1:0] : s5_nx_q[MW-1:0];
      s6_nym_q  <= s5_ny_q[XW-1] ? ny_neg[MW-1:0] : s5_ny_q[MW-1:0];
      s6_detm_q <= s5_det_q[DW-1] ? det_neg[GW-1:0] : s5_det_q[GW-1:0];
      s6_n2_q   <= s5_n2_q;
      s6_s_q    <= s5_s_q;

      // Stage 7: quotients that cannot fit are caught here; the dividers start.
      s7_q.mode    <= s6_mode_q;
      s7_q.par     <= s6_par_q;
      s7_q.neg_x   <= s6_negx_q;
      s7_q.neg_y   <= s6_negy_q;
      s7_q.ovf_x   <= s6_nxm_q[MW-1:QW] >= {1'b0, s6_detm_q};
      s7_q.ovf_y   <= s6_nym_q[MW-1:QW] >= {1'b0, s6_detm_q};
      s7_q.ovf_g   <= s6_n2_q[N2-1:GW] >= s6_s_q;
      s7_q.det_mag <= s6_detm_q;
      s7_q.rx      <= s6_nxm_q[MW-2:QW];
      s7_q.lx      <= s6_nxm_q[QW-1:0];
      s7_q.ry      <= s6_nym_q[MW-2:QW];
      s7_q.ly      <= s6_nym_q[QW-1:0];
      s7_q.s       <= s6_s_q;
      s7_q.rg      <= s6_n2_q[N2-1:GW];
      s7_q.lg      <= s6_n2_q[GW-1:0];
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign div_o   = s7_q;

endmodule

// ----- rtl/lid_divide.sv -----
// Restoring divider pipeline: crossing quotients in the first stages, distance quotient in all.
module lid_divide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  lid_pkg::div_t div_i,
  output logic          valid_o,
  output lid_pkg::div_t div_o
);

  localparam int unsigned NSTG = lid_pkg::GDIV_STEPS;
  localparam int unsigned XQ   = lid_pkg::XDIV_STEPS;
  localparam int unsigned GQ   = lid_pkg::GDIV_STEPS;

  logic [NSTG-1:0] vld_q;
  lid_pkg::div_t   stg_q [NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    lid_pkg::div_t  src;
    lid_pkg::div_t  nxt;
    lid_pkg::dstep_t sx, sy, sg;

    if (k == 0) begin : g_first
      assign src = div_i;
    end else begin : g_next
      assign src = stg_q[k-1];
    end

    assign sx = lid_pkg::div_step(src.rx, src.lx[XQ-1], src.det_mag);
    assign sy = lid_pkg::div_step(src.ry, src.ly[XQ-1], src.det_mag);
    assign sg = lid_pkg::div_step(src.rg, src.lg[GQ-1], src.s);

    always_comb begin
      nxt    = src;
      nxt.rg = sg.r;
      nxt.lg = {src.lg[GQ-2:0], sg.q};
      // The crossing quotients are complete after their own number of steps.
      if (k < XQ) begin
        nxt.rx = sx.r;
        nxt.lx = {src.lx[XQ-2:0], sx.q};
        nxt.ry = sy.r;
        nxt.ly = {src.ly[XQ-2:0], sy.q};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign div_o   = stg_q[NSTG-1];

endmodule

// ----- rtl/lid_isqrt.sv -----
// Square root pipeline, one root bit per stage, carrying the crossing quotients alongside.
module lid_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  lid_pkg::div_t div_i,
  output logic          valid_o,
  output lid_pkg::sqr_t sqr_o
);

  localparam int unsigned NSTG = lid_pkg::ROOT_W;
  localparam int unsigned RW   = lid_pkg::REM_W;
  localparam int unsigned AW   = lid_pkg::RAD_W;

  logic [NSTG-1:0] vld_q;
  lid_pkg::sqr_t   stg_q [NSTG];
  lid_pkg::sqr_t   init;

  always_comb begin
    init.mode  = div_i.mode;
    init.par   = div_i.par;
    init.neg_x = div_i.neg_x;
    init.neg_y = div_i.neg_y;
    init.ovf_x = div_i.ovf_x;
    init.ovf_y = div_i.ovf_y;
    init.ovf_g = div_i.ovf_g;
    init.qx    = div_i.lx;
    init.qy    = div_i.ly;
    init.rad   = div_i.lg;
    init.rem   = '0;
    init.root  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    lid_pkg::sqr_t src;
    lid_pkg::sqr_t nxt;
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = stg_q[k-1];
    end

    assign t     = {src.rem, src.rad[AW-1:AW-2]};
    assign trial = {2'b00, src.root, 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_comb begin
      nxt      = src;
      nxt.rem  = ge ? diff[RW-1:0] : t[RW-1:0];
      nxt.root = {src.root[NSTG-2:0], ge};
      nxt.rad  = {src.rad[AW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign sqr_o   = stg_q[NSTG-1];

endmodule

// ----- rtl/lid_checker.sv -----
// Port-level checker for the line intersection and distance block, bound to the top level.
module lid_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // A result that is held back keeps its value.
  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
                                             && $stable(m_axis_tuser));
  endproperty
  a_hold: assert property (p_hold) else $error("output changed while stalled");

  // The slave side only stalls behind a waiting result.
  property p_ready;
    @(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready);
  endproperty
  a_ready: assert property (p_ready) else $error("input stalled without output back-pressure");

  // Parallel lines give a zero crossing and never report saturation.
  property p_par;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]);
  endproperty
  a_par: assert property (p_par) else $error("parallel result not cleared");

  // A distance result carries no crossing point and a crossing result no distance.
  property p_excl;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[95:64] == '0 || m_axis_tdata[63:0] == '0);
  endproperty
  a_excl: assert property (p_excl) else $error("crossing and distance both non-zero");

endmodule

bind line_intersect_and_distance_2d lid_checker u_lid_checker (.*);
